/* hdl/clt_pkg.sv */
// Shared types and constants for the color lookup table engine.
`default_nettype none

package clt_pkg;

    localparam int LANES           = 4;
    localparam int LANE_W          = 8;
    localparam int ENTRIES_DEFAULT = 256;
    localparam int GAIN_W          = 17;
    localparam int AMOUNT_W        = 9;
    localparam logic [LANE_W-1:0] LANE_MAX = 8'd255;

    typedef enum logic [2:0] {
        CMD_RESET    = 3'd0,
        CMD_SATURATE = 3'd1,
        CMD_MULTIPLY = 3'd2,
        CMD_ADD      = 3'd3,
        CMD_INVERT   = 3'd4,
        CMD_WRITE    = 3'd5,
        CMD_READ     = 3'd6,
        CMD_UNUSED   = 3'd7
    } cmd_t;

    typedef logic [LANES-1:0][LANE_W-1:0] lut_word_t;

    // Operands held for the duration of one table sweep
    typedef struct packed {
        cmd_t                        cmd;
        logic [LANE_W-1:0]           low;
        logic [LANE_W-1:0]           high;
        logic [GAIN_W-1:0]           gain_mag;
        logic signed [AMOUNT_W-1:0]  amount;
    } lane_ctrl_t;

endpackage

`default_nettype wire

/* hdl/color_lut_table_engine.sv */
// Top level: table memory, sweep sequencer and result registers.
//
// Usage: one command channel (start/busy) and one result channel (done).
// A command is taken at a rising edge with start high and busy low; its
// fields are sampled only at that edge. Each command yields exactly one
// result: done is high for one cycle with status and read_data valid.
// The receiver cannot stall; done is never held.
//
// From the accepting edge to done:
//   table commands (reset, saturate, multiply, add, invert): the sweep
//     state passes one entry per cycle through the memory's read port,
//     the lane unit and the write port, then the finish state raises done
//   rejected saturate, write entry, unused code: done is set at the accepting edge; busy stays low
//   read entry: registered memory read, then the result register
// For the others, busy stays high from the accepting edge until the cycle done shows, so
// one command runs at a time; a new command may be taken in that cycle.
// After reset the block loads the identity ramp into every entry, one
// entry per cycle, and holds busy high until the last entry is written.
`default_nettype none

module color_lut_table_engine
    import clt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         cmd,
    input  wire logic [3:0]         channels,
    input  wire logic signed [9:0]  low_bound,
    input  wire logic signed [9:0]  high_bound,
    input  wire logic signed [16:0] gain,
    input  wire logic signed [10:0] add_amount,
    input  wire logic [7:0]         entry_index,
    input  wire logic [7:0]         entry_value,
    input  wire logic [1:0]         read_channel,
    output logic                    done,
    output logic                    status,
    output logic [7:0]              read_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_READ   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               wr_valid_reg, wr_valid_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    lane_ctrl_t         ctrl_reg, ctrl_next;
    logic [LANES-1:0]   mask_reg, mask_next;
    logic [1:0]         rd_ch_reg, rd_ch_next;
    logic               idx_ok_reg, idx_ok_next;
    logic               done_reg, done_next;
    logic               status_reg, status_next;
    logic [LANE_W-1:0]  rd_data_reg, rd_data_next;
    lut_word_t          rd_word_reg;

    lut_word_t          lut_mem [ENTRIES];

    logic               accept;
    cmd_t               cmd_in;
    logic [LANE_W-1:0]  low_clamp, high_clamp;
    logic [GAIN_W-1:0]  gain_mag;
    logic signed [AMOUNT_W-1:0] amount_clamp;
    logic               sat_fail;
    logic               idx_ok;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    lut_word_t          mem_wdata;
    logic [LANES-1:0]   mem_be;
    lut_word_t          alu_word;

    assign accept = start && !busy;
    assign cmd_in = cmd_t'(cmd);
    assign idx_ok = ({1'b0, entry_index} < 9'(ENTRIES));

    // Clamp the bounds and the add amount at the input; take the gain's magnitude
    always_comb
    begin
        if (low_bound[9])
            low_clamp = '0;
        else if (low_bound[8])
            low_clamp = LANE_MAX;
        else
            low_clamp = low_bound[7:0];

        if (high_bound[9])
            high_clamp = '0;
        else if (high_bound[8])
            high_clamp = LANE_MAX;
        else
            high_clamp = high_bound[7:0];

        if (add_amount < -11'sd255)
            amount_clamp = -9'sd255;
        else if (add_amount > 11'sd255)
            amount_clamp = 9'sd255;
        else
            amount_clamp = add_amount[8:0];

        gain_mag = gain[16] ? (~gain + 17'd1) : gain;
    end

    assign sat_fail = (cmd_in == CMD_SATURATE) && (high_clamp < low_clamp);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wr_valid_next = (state_reg == ST_SWEEP);
        wr_idx_next   = cnt_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        rd_ch_next    = rd_ch_reg;
        idx_ok_next   = idx_ok_reg;
        done_next     = 1'b0;
        status_next   = 1'b0;
        rd_data_next  = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl_next.cmd      = cmd_in;
                    ctrl_next.low      = low_clamp;
                    ctrl_next.high     = high_clamp;
                    ctrl_next.gain_mag = gain_mag;
                    ctrl_next.amount   = amount_clamp;
                    rd_ch_next         = read_channel;
                    idx_ok_next        = idx_ok;
                    mask_next          = channels;
                    if ((cmd_in == CMD_ADD) && (amount_clamp == '0))
                        mask_next = '0;
                    priority if (sat_fail)
                    begin
                        done_next   = 1'b1;
                        status_next = 1'b1;
                    end
                    else if (cmd_in == CMD_RESET || cmd_in == CMD_SATURATE ||
                             cmd_in == CMD_MULTIPLY || cmd_in == CMD_ADD ||
                             cmd_in == CMD_INVERT)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    else if (cmd_in == CMD_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                done_next    = 1'b1;
                rd_data_next = idx_ok_reg ? rd_word_reg[rd_ch_reg] : '0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            wr_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= 1'b0;
            rd_data_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            wr_valid_reg <= wr_valid_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            rd_data_reg  <= rd_data_next;
        end
    end

    // Operand registers hold for the length of one transaction; the write-back index follows the counter
    always_ff @(posedge clk)
    begin
        wr_idx_reg <= wr_idx_next;
        ctrl_reg   <= ctrl_next;
        mask_reg   <= mask_next;
        rd_ch_reg  <= rd_ch_next;
        idx_ok_reg <= idx_ok_next;
    end

    clt_lane_alu u_alu
    (
        .ctrl     (ctrl_reg),
        .ramp     (8'(wr_idx_reg)),
        .word_in  (rd_word_reg),
        .word_out (alu_word)
    );

    // Select the write port source: ramp fill, sweep write-back or entry write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_be    = '0;
        mem_waddr = cnt_reg;
        mem_wdata = alu_word;
        priority if (state_reg == ST_INIT)
        begin
            mem_we    = 1'b1;
            mem_be    = '1;
            mem_wdata = {LANES{8'(cnt_reg)}};
        end
        else if (wr_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_be    = mask_reg;
            mem_waddr = wr_idx_reg;
        end
        else if (accept && (cmd_in == CMD_WRITE) && idx_ok)
        begin
            mem_we    = 1'b1;
            mem_be    = channels;
            mem_waddr = entry_index[IDX_W-1:0];
            mem_wdata = {LANES{entry_value}};
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_raddr = (state_reg == ST_SWEEP) ? cnt_reg : entry_index[IDX_W-1:0];

    // Table memory: one write port with lane enables, one registered read port
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (mem_we && mem_be[l])
                lut_mem[mem_waddr][l] <= mem_wdata[l];
        end
        rd_word_reg <= lut_mem[mem_raddr];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign read_data = rd_data_reg;

    // A result is shown only once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result strobe while busy");

    // Write-back happens only in the cycle after a sweep read
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> $past(state_reg == ST_SWEEP))
        else $error("write-back without a sweep read");

    // A rejected saturate reports its error in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && sat_fail |=> done_reg && status_reg)
        else $error("rejected saturate did not report status");

    // An error result never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg |-> rd_data_reg == '0)
        else $error("error result carries read data");

endmodule

`default_nettype wire

/* hdl/clt_lane_alu.sv */
// Four-lane entry update unit shared by every table-wide command.
`default_nettype none

module clt_lane_alu
    import clt_pkg::*;
(
    input  wire lane_ctrl_t          ctrl,
    input  wire logic [LANE_W-1:0]   ramp,
    input  wire lut_word_t           word_in,
    output lut_word_t                word_out
);

    // Update each lane of the word independently
    always_comb
    begin
        logic [LANE_W-1:0]              e;
        logic [LANE_W+GAIN_W-1:0]       prod;
        logic [GAIN_W-1:0]              scaled;
        logic signed [LANE_W+1:0]       sum;
        for (int l = 0; l < LANES; l++)
        begin
            e      = word_in[l];
            prod   = (LANE_W+GAIN_W)'(e) * (LANE_W+GAIN_W)'(ctrl.gain_mag);
            scaled = prod[LANE_W+GAIN_W-1:LANE_W];
            sum    = $signed({2'b00, e}) + (LANE_W+2)'(ctrl.amount);
            unique case (ctrl.cmd)
                CMD_RESET:
                    word_out[l] = ramp;
                CMD_SATURATE:
                begin
                    if (e < ctrl.low)
                        word_out[l] = ctrl.low;
                    else if (e > ctrl.high)
                        word_out[l] = ctrl.high;
                    else
                        word_out[l] = e;
                end
                CMD_MULTIPLY:
                    word_out[l] = (scaled > GAIN_W'(LANE_MAX)) ? LANE_MAX
                                                                : scaled[LANE_W-1:0];
                CMD_ADD:
                begin
                    if (sum[LANE_W+1])
                        word_out[l] = '0;
                    else if (sum[LANE_W])
                        word_out[l] = LANE_MAX;
                    else
                        word_out[l] = sum[LANE_W-1:0];
                end
                CMD_INVERT:
                    word_out[l] = ~e;
                default:
                    word_out[l] = e;
            endcase
        end
    end

endmodule

`default_nettype wire
